@@ hdl/ckf_pkg.sv @@
// Shared types and constants for the Catmull-Rom keyframe interpolator.
`timescale 1ns / 1ps
package ckf_pkg;

	localparam int MAX_KEYS_DEF = 64;
	localparam int NCHAN        = 10;
	localparam int QCH0         = 6;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 336;

	localparam int DIV_NW = 47;
	localparam int DIV_DW = 31;
	localparam int DIV_QW = 17;

	localparam logic [3:0] REG_TOTAL_FRAMES = 4'd0;
	localparam logic [3:0] REG_KEY_COUNT    = 4'd1;
	localparam logic [3:0] CH_FRAME         = 4'd10;

	typedef struct packed {
		logic wr;
		logic start;
		logic srch_cmp;
		logic seg_s;
		logic seg_e;
		logic den;
		logic u_load;
		logic ch_rd;
		logic coef;
		logic mul;
		logic add;
		logic ch_out;
		logic norm_init;
		logic norm_sh;
		logic sq;
		logic sqrt;
		logic qd_start;
		logic qd_store;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic srch_more;
		logic div_done;
		logic rd_last;
		logic h_last;
		logic ch_last;
		logic q_zero;
		logic norm_ok;
		logic sq_last;
		logic sqrt_last;
		logic qd_last;
		logic out_free;
	} sts_t;

endpackage

@@ hdl/ckf_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ckf_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ckf_pkg::DIV_NW-1:0] dividend,
	input  logic [ckf_pkg::DIV_DW-1:0] divisor,
	output logic                       done,
	output logic [ckf_pkg::DIV_QW-1:0] quotient
);
	import ckf_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_QW-1:0] dq_q;
	logic [DIV_DW-1:0] dvs_q;
	logic [DIV_DW+1:0] trial;

	assign trial = {1'b0, rem_q, dq_q[DIV_QW-1]} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// the upper dividend bits are known to lie below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend[DIV_NW-1:DIV_QW]};
			dq_q  <= dividend[DIV_QW-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DIV_DW+1])
				rem_q <= trial[DIV_DW-1:0];
			else
				rem_q <= {rem_q[DIV_DW-2:0], dq_q[DIV_QW-1]};
			dq_q <= {dq_q[DIV_QW-2:0], ~trial[DIV_DW+1]};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

@@ hdl/ckf_dp.sv @@
// Datapath: keyframe memories, segment search, cubic evaluation, normalization.
`timescale 1ns / 1ps
module ckf_dp #(
	parameter int MAX_KEYS = ckf_pkg::MAX_KEYS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ckf_pkg::cmd_t                   cmd,
	output ckf_pkg::sts_t                   sts,
	input  logic [ckf_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                            cfg_valid,
	input  logic [3:0]                      cfg_index,
	input  logic [15:0]                     cfg_data,
	input  logic                            m_tready,
	output logic                            m_tvalid,
	output logic [ckf_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import ckf_pkg::*;

	localparam int KW  = $clog2(MAX_KEYS);
	localparam int NW  = KW + 1;
	localparam int CD  = MAX_KEYS * NCHAN;
	localparam int CAW = $clog2(CD);

	function automatic logic [CAW-1:0] caddr(input logic [KW-1:0] k, input logic [3:0] c);
		return CAW'({k, 3'b000}) + CAW'({k, 1'b0}) + CAW'(c);
	endfunction

	logic [5:0]  in_key;
	logic [3:0]  in_chan;
	logic [31:0] in_val;
	assign in_key  = s_tdata[5:0];
	assign in_chan = s_tdata[9:6];
	assign in_val  = s_tdata[41:10];

	logic [15:0] total_q;
	logic [6:0]  kc_q;
	logic [15:0] cur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= 16'd1;
			kc_q    <= 7'd1;
		end else if (cfg_valid) begin
			if (cfg_index == REG_TOTAL_FRAMES)
				total_q <= cfg_data;
			else if (cfg_index == REG_KEY_COUNT)
				kc_q <= cfg_data[6:0];
		end
	end

	// keyframe memories
	logic [15:0] kf_mem [MAX_KEYS];
	logic [31:0] ch_mem [CD];
	logic [15:0] kf_rd;
	logic [31:0] ch_rdata;

	logic [KW+5:0]   key_ext;
	logic [KW-1:0]   wr_key;
	logic            wr_ok;
	assign key_ext = {{KW{1'b0}}, in_key};
	assign wr_key  = key_ext[KW-1:0];
	assign wr_ok   = 32'(in_key) < 32'(MAX_KEYS);

	logic [KW-1:0]  idx_q, start_q, end_q, after_q, before_q;
	logic [NW-1:0]  n_q;
	logic [4:0]     cnt_q;
	logic [3:0]     ch_q;
	logic [KW-1:0]  kf_raddr;
	logic [KW-1:0]  ksel;
	logic [CAW-1:0] ch_raddr;

	assign kf_raddr = cmd.seg_s ? start_q : (cmd.seg_e ? end_q : idx_q);

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0:    ksel = before_q;
			2'd1:    ksel = start_q;
			2'd2:    ksel = end_q;
			default: ksel = after_q;
		endcase
	end
	assign ch_raddr = caddr(ksel, ch_q);

	always_ff @(posedge clk) begin
		if (cmd.wr && wr_ok) begin
			if (in_chan < 4'(NCHAN))
				ch_mem[caddr(wr_key, in_chan)] <= in_val;
			else if (in_chan == CH_FRAME)
				kf_mem[wr_key] <= in_val[15:0];
		end
		kf_rd    <= kf_mem[kf_raddr];
		ch_rdata <= ch_mem[ch_raddr];
	end

	// segment search and neighbors
	logic [31:0]   n32, n32m1;
	logic [NW-1:0] nm1_w, idx_p1;
	logic [KW-1:0] last_key, end_w, after_w, before_w;
	logic          le;

	assign n32 = (kc_q == 7'd0) ? 32'd1 :
	             ((32'(kc_q) > 32'(MAX_KEYS)) ? 32'(MAX_KEYS) : 32'(kc_q));
	assign n32m1    = n32 - 32'd1;
	assign nm1_w    = n_q - NW'(1);
	assign last_key = nm1_w[KW-1:0];
	assign end_w    = (start_q == last_key) ? '0 : start_q + KW'(1);
	assign after_w  = (end_w == last_key) ? '0 : end_w + KW'(1);
	assign before_w = (start_q == '0) ? last_key : start_q - KW'(1);
	assign le       = kf_rd <= cur_q;
	assign idx_p1   = {1'b0, idx_q} + NW'(1);

	// interpolation parameter
	logic [15:0]        fs_q;
	logic               uz_q, usat_q;
	logic [16:0]        u_q;
	logic signed [17:0] num_w, den_w;
	logic [16:0]        absn_w, absd_w;

	assign num_w  = $signed({2'b00, cur_q}) - $signed({2'b00, fs_q});
	assign den_w  = (kf_rd > fs_q) ? $signed({2'b00, kf_rd}) - $signed({2'b00, fs_q})
	                               : $signed({2'b00, total_q}) - $signed({2'b00, fs_q});
	assign absn_w = num_w[17] ? 17'(-num_w) : num_w[16:0];
	assign absd_w = den_w[17] ? 17'(-den_w) : den_w[16:0];

	// cubic evaluation
	logic signed [31:0] p_q   [4];
	logic signed [37:0] a_q   [4];
	logic signed [37:0] t_q;
	logic signed [55:0] prod_q;
	logic signed [37:0] pe0, pe1, pe2, pe3;
	logic signed [55:0] rnd_w;
	logic signed [37:0] half_w;
	logic signed [31:0] sat_w;

	assign pe0    = 38'(p_q[0]);
	assign pe1    = 38'(p_q[1]);
	assign pe2    = 38'(p_q[2]);
	assign pe3    = 38'(p_q[3]);
	assign rnd_w  = (prod_q + 56'sd32768) >>> 16;
	assign half_w = (t_q + 38'sd1) >>> 1;
	assign sat_w  = (half_w > 38'sd2147483647) ? 32'sh7fffffff :
	                ((half_w < -38'sd2147483648) ? 32'sh80000000 : half_w[31:0]);

	// quaternion normalization
	logic signed [31:0] res_q [NCHAN];
	logic [31:0]        mag_q [4];
	logic [31:0]        mag_w [4];
	logic [31:0]        mx_q, mx_w;
	logic [59:0]        sq_q;
	logic [61:0]        acc_q;
	logic [63:0]        sv_q, sr_q, bitv, cand;
	logic [4:0]         bexp;
	logic [30:0]        norm_w;
	logic [1:0]         qj;
	logic [3:0]         qidx;

	always_comb begin
		mx_w = '0;
		for (int j = 0; j < 4; j++) begin
			mag_w[j] = res_q[QCH0 + j][31] ? 32'(-res_q[QCH0 + j]) : res_q[QCH0 + j];
			if (mag_w[j] > mx_w)
				mx_w = mag_w[j];
		end
	end

	assign bexp   = ~cnt_q;
	assign bitv   = 64'd1 << {bexp, 1'b0};
	assign cand   = sr_q + bitv;
	assign norm_w = sr_q[30:0];
	assign qj     = cnt_q[1:0];
	assign qidx   = 4'(QCH0) + {2'b00, qj};

	// shared divider
	logic                div_start, div_done;
	logic [DIV_NW-1:0]   div_dvd;
	logic [DIV_QW-1:0]   div_q;
	logic [DIV_NW-1:0]   u_dvd, q_dvd;

	assign u_dvd     = DIV_NW'({absn_w, 16'h0000});
	assign q_dvd     = DIV_NW'({mag_q[qj][29:0], 16'h0000}) + DIV_NW'(norm_w >> 1);
	assign div_start = cmd.den | cmd.qd_start;
	assign div_dvd   = cmd.den ? u_dvd : q_dvd;

	ckf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (cmd.den ? DIV_DW'(absd_w) : norm_w),
		.done     (div_done),
		.quotient (div_q)
	);

	logic        m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q, out_w;
	logic [15:0] cur_inc;

	assign cur_inc = cur_q + 16'd1;

	always_comb begin
		out_w = '0;
		out_w[15:0] = cur_q;
		for (int c = 0; c < NCHAN; c++)
			out_w[16 + 32 * c +: 32] = res_q[c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.fin) begin
				m_tvalid_q <= 1'b1;
				cur_q      <= (cur_inc == total_q) ? 16'd0 : cur_inc;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin)
			m_tdata_q <= out_w;

		if (cmd.start) begin
			n_q     <= n32[NW-1:0];
			idx_q   <= '0;
			start_q <= n32m1[KW-1:0];
		end
		if (cmd.srch_cmp) begin
			if (le)
				start_q <= idx_q;
			idx_q <= idx_q + KW'(1);
		end
		if (cmd.seg_s) begin
			end_q    <= end_w;
			after_q  <= after_w;
			before_q <= before_w;
		end
		if (cmd.seg_e)
			fs_q <= kf_rd;
		if (cmd.den) begin
			uz_q   <= (den_w == '0) || (num_w == '0) || (num_w[17] != den_w[17]);
			usat_q <= absn_w >= absd_w;
		end
		if (cmd.u_load) begin
			u_q   <= uz_q ? 17'd0 : (usat_q ? 17'h10000 : div_q);
			cnt_q <= '0;
			ch_q  <= '0;
		end
		if (cmd.ch_rd) begin
			if (cnt_q != 5'd0)
				p_q[cnt_q[1:0] - 2'd1] <= ch_rdata;
			cnt_q <= cnt_q + 5'd1;
		end
		if (cmd.coef) begin
			a_q[0] <= pe1 <<< 1;
			a_q[1] <= pe2 - pe0;
			a_q[2] <= (pe0 <<< 1) - (pe1 <<< 2) - pe1 + (pe2 <<< 2) - pe3;
			a_q[3] <= -pe0 + (pe1 <<< 1) + pe1 - (pe2 <<< 1) - pe2 + pe3;
			t_q    <= -pe0 + (pe1 <<< 1) + pe1 - (pe2 <<< 1) - pe2 + pe3;
			cnt_q  <= '0;
		end
		if (cmd.mul)
			prod_q <= 56'(t_q) * 56'($signed({1'b0, u_q}));
		if (cmd.add) begin
			t_q   <= a_q[2'd2 - cnt_q[1:0]] + rnd_w[37:0];
			cnt_q <= cnt_q + 5'd1;
		end
		if (cmd.ch_out) begin
			res_q[ch_q] <= sat_w;
			ch_q        <= ch_q + 4'd1;
			cnt_q       <= '0;
		end
		if (cmd.norm_init) begin
			for (int j = 0; j < 4; j++)
				mag_q[j] <= mag_w[j];
			mx_q  <= mx_w;
			acc_q <= '0;
			cnt_q <= '0;
		end
		// bring the largest magnitude into [2^29, 2^30)
		if (cmd.norm_sh) begin
			if (mx_q[31:30] != 2'b00) begin
				for (int j = 0; j < 4; j++)
					mag_q[j] <= mag_q[j] >> 1;
				mx_q <= mx_q >> 1;
			end else if (!mx_q[29]) begin
				for (int j = 0; j < 4; j++)
					mag_q[j] <= mag_q[j] << 1;
				mx_q <= mx_q << 1;
			end
		end
		if (cmd.sq) begin
			if (cnt_q < 5'd4)
				sq_q <= mag_q[cnt_q[1:0]][29:0] * mag_q[cnt_q[1:0]][29:0];
			if (cnt_q == 5'd4) begin
				sv_q  <= 64'(acc_q) + 64'(sq_q);
				sr_q  <= '0;
				cnt_q <= '0;
			end else begin
				if (cnt_q != 5'd0)
					acc_q <= acc_q + 62'(sq_q);
				cnt_q <= cnt_q + 5'd1;
			end
		end
		if (cmd.sqrt) begin
			if (sv_q >= cand) begin
				sv_q <= sv_q - cand;
				sr_q <= (sr_q >> 1) + bitv;
			end else begin
				sr_q <= sr_q >> 1;
			end
			cnt_q <= cnt_q + 5'd1;
		end
		if (cmd.qd_store) begin
			res_q[qidx] <= res_q[qidx][31] ? -$signed(32'(div_q)) : $signed(32'(div_q));
			cnt_q       <= cnt_q + 5'd1;
		end
	end

	always_comb begin
		sts.srch_more = le && (idx_p1 < n_q);
		sts.div_done  = div_done;
		sts.rd_last   = cnt_q == 5'd4;
		sts.h_last    = cnt_q == 5'd2;
		sts.ch_last   = ch_q == 4'(NCHAN - 1);
		sts.q_zero    = mx_w == '0;
		sts.norm_ok   = (mx_q[31:30] == 2'b00) && mx_q[29];
		sts.sq_last   = cnt_q == 5'd4;
		sts.sqrt_last = cnt_q == 5'd31;
		sts.qd_last   = qj == 2'd3;
		sts.out_free  = !m_tvalid_q || m_tready;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ hdl/ckf_ctrl.sv @@
// Controller state machine sequencing the interpolation datapath.
`timescale 1ns / 1ps
module ckf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          mode,
	input  ckf_pkg::sts_t sts,
	output ckf_pkg::cmd_t cmd,
	output logic          s_tready
);
	import ckf_pkg::*;

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_SRD   = 5'd1;
	localparam logic [4:0] ST_SCMP  = 5'd2;
	localparam logic [4:0] ST_SEGS  = 5'd3;
	localparam logic [4:0] ST_SEGE  = 5'd4;
	localparam logic [4:0] ST_DEN   = 5'd5;
	localparam logic [4:0] ST_DIVU  = 5'd6;
	localparam logic [4:0] ST_CHRD  = 5'd7;
	localparam logic [4:0] ST_COEF  = 5'd8;
	localparam logic [4:0] ST_MUL   = 5'd9;
	localparam logic [4:0] ST_ADD   = 5'd10;
	localparam logic [4:0] ST_CHOUT = 5'd11;
	localparam logic [4:0] ST_NINIT = 5'd12;
	localparam logic [4:0] ST_NSH   = 5'd13;
	localparam logic [4:0] ST_SQ    = 5'd14;
	localparam logic [4:0] ST_SQRT  = 5'd15;
	localparam logic [4:0] ST_QDS   = 5'd16;
	localparam logic [4:0] ST_QDW   = 5'd17;
	localparam logic [4:0] ST_FIN   = 5'd18;

	logic [4:0] state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (mode) begin
						cmd.start = 1'b1;
						state_nxt = ST_SRD;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			ST_SRD:  state_nxt = ST_SCMP;
			ST_SCMP: begin
				cmd.srch_cmp = 1'b1;
				state_nxt    = sts.srch_more ? ST_SRD : ST_SEGS;
			end
			ST_SEGS: begin
				cmd.seg_s = 1'b1;
				state_nxt = ST_SEGE;
			end
			ST_SEGE: begin
				cmd.seg_e = 1'b1;
				state_nxt = ST_DEN;
			end
			ST_DEN: begin
				cmd.den   = 1'b1;
				state_nxt = ST_DIVU;
			end
			ST_DIVU: begin
				if (sts.div_done) begin
					cmd.u_load = 1'b1;
					state_nxt  = ST_CHRD;
				end
			end
			ST_CHRD: begin
				cmd.ch_rd = 1'b1;
				if (sts.rd_last)
					state_nxt = ST_COEF;
			end
			ST_COEF: begin
				cmd.coef  = 1'b1;
				state_nxt = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_ADD;
			end
			ST_ADD: begin
				cmd.add   = 1'b1;
				state_nxt = sts.h_last ? ST_CHOUT : ST_MUL;
			end
			ST_CHOUT: begin
				cmd.ch_out = 1'b1;
				state_nxt  = sts.ch_last ? ST_NINIT : ST_CHRD;
			end
			ST_NINIT: begin
				cmd.norm_init = 1'b1;
				state_nxt     = sts.q_zero ? ST_FIN : ST_NSH;
			end
			ST_NSH: begin
				cmd.norm_sh = 1'b1;
				if (sts.norm_ok)
					state_nxt = ST_SQ;
			end
			ST_SQ: begin
				cmd.sq = 1'b1;
				if (sts.sq_last)
					state_nxt = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt = 1'b1;
				if (sts.sqrt_last)
					state_nxt = ST_QDS;
			end
			ST_QDS: begin
				cmd.qd_start = 1'b1;
				state_nxt    = ST_QDW;
			end
			ST_QDW: begin
				if (sts.div_done) begin
					cmd.qd_store = 1'b1;
					state_nxt    = sts.qd_last ? ST_FIN : ST_QDS;
				end
			end
			ST_FIN: begin
				// hold until the output register is free
				if (sts.out_free) begin
					cmd.fin   = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	assign s_tready = state_q == ST_IDLE;

endmodule

@@ hdl/catmull_rom_keyframe_interpolator_unit.sv @@
// A write transaction is taken in the idle state; a render runs the segment search,
// a division for u, ten cubics, the normalizing shifts, a square root and four divisions,
// and it skips the normalization when the quaternion is zero.
// One render at a time; the next item is accepted while the result waits.
// Reset (arst_n low) clears the frame counter and sets total_frames and key_count to 1;
// the keyframe memories are not cleared and must be written before use.
`timescale 1ns / 1ps
module catmull_rom_keyframe_interpolator_unit #(
	parameter int MAX_KEYS = ckf_pkg::MAX_KEYS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ckf_pkg::IN_TDATA_W-1:0]  s_tdata,  // key_index, channel, value
	input  logic [0:0]                      s_tuser,  // mode
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// frame_index, trans_x/y/z, scale_x/y/z, quat_s/x/y/z
	output logic [ckf_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [3:0]                      cfg_index,
	input  logic [15:0]                     cfg_data
);
	import ckf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	ckf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.mode     (s_tuser[0]),
		.sts      (sts),
		.cmd      (cmd),
		.s_tready (s_tready)
	);

	ckf_dp #(
		.MAX_KEYS (MAX_KEYS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

endmodule
